FILE: sv/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and constants for the triangle edge setup pipeline.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int SLOPE_BITS = 32;
  // numerator magnitude: |dx| < 2^(COORD_BITS), shifted by FRAC_BITS
  localparam int NUM_BITS   = COORD_BITS + 1 + FRAC_BITS;
  // divisor dy + 1 is at most 2^COORD_BITS
  localparam int DEN_BITS   = COORD_BITS + 1;
  localparam int ROW_BITS   = 12;
  localparam int N_EDGES    = 3;

  localparam logic [2:0] FLAG_AB = 3'h4;
  localparam logic [2:0] FLAG_BC = 3'h2;
  localparam logic [2:0] FLAG_AC = 3'h1;

  localparam logic [2:0] CODE_CBA = 3'h0;
  localparam logic [2:0] CODE_BCA = 3'h2;
  localparam logic [2:0] CODE_BAC = 3'h3;
  localparam logic [2:0] CODE_CAB = 3'h4;
  localparam logic [2:0] CODE_ACB = 3'h5;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one divide request: magnitudes and result sign
  typedef struct packed {
    logic [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
    logic                neg;
  } div_req_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    coord_t             top_x;
    coord_t             top_y;
    logic [ROW_BITS-1:0] rows_upper;
    logic [ROW_BITS-1:0] rows_total;
  } side_t;

endpackage

FILE: sv/tes_sort.sv
// ----------------------------------------------------------------------------
// tes_sort
// Two-stage front end: vertex sort by y, then edge deltas as divide requests.
// ----------------------------------------------------------------------------
module tes_sort (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  tes_pkg::coord_t                        ax,
  input  tes_pkg::coord_t                        ay,
  input  tes_pkg::coord_t                        bx,
  input  tes_pkg::coord_t                        by,
  input  tes_pkg::coord_t                        cx,
  input  tes_pkg::coord_t                        cy,
  output logic                                   req_vld,
  output tes_pkg::div_req_t [tes_pkg::N_EDGES-1:0] req,
  output tes_pkg::side_t                         side
);

  localparam int CB = tes_pkg::COORD_BITS;
  localparam int DB = tes_pkg::DEN_BITS;
  localparam int RB = tes_pkg::ROW_BITS;

  logic [2:0] code;
  tes_pkg::coord_t tx_nxt, ty_nxt, mx_nxt, my_nxt, bx_nxt, by_nxt;
  tes_pkg::coord_t tx_r, ty_r, mx_r, my_r, bx_r, by_r;
  logic s1_vld_r, s2_vld_r;
  tes_pkg::div_req_t [tes_pkg::N_EDGES-1:0] req_nxt, req_r;
  tes_pkg::side_t side_nxt, side_r;

  // compare flags and sort select
  always_comb begin
    code = ((ay >= by) ? tes_pkg::FLAG_AB : 3'h0)
         | ((by >= cy) ? tes_pkg::FLAG_BC : 3'h0)
         | ((ay >= cy) ? tes_pkg::FLAG_AC : 3'h0);
    case (code)
      tes_pkg::CODE_CBA: begin
        tx_nxt = cx; ty_nxt = cy; mx_nxt = bx; my_nxt = by; bx_nxt = ax; by_nxt = ay;
      end
      tes_pkg::CODE_BCA: begin
        tx_nxt = bx; ty_nxt = by; mx_nxt = cx; my_nxt = cy; bx_nxt = ax; by_nxt = ay;
      end
      tes_pkg::CODE_BAC: begin
        tx_nxt = bx; ty_nxt = by; mx_nxt = ax; my_nxt = ay; bx_nxt = cx; by_nxt = cy;
      end
      tes_pkg::CODE_CAB: begin
        tx_nxt = cx; ty_nxt = cy; mx_nxt = ax; my_nxt = ay; bx_nxt = bx; by_nxt = by;
      end
      tes_pkg::CODE_ACB: begin
        tx_nxt = ax; ty_nxt = ay; mx_nxt = cx; my_nxt = cy; bx_nxt = bx; by_nxt = by;
      end
      default: begin
        tx_nxt = ax; ty_nxt = ay; mx_nxt = bx; my_nxt = by; bx_nxt = cx; by_nxt = cy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    tx_r <= tx_nxt; ty_r <= ty_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt;
    req_r  <= req_nxt;
    side_r <= side_nxt;
  end

  // build one signed-magnitude request for an edge
  function automatic tes_pkg::div_req_t mk_req(input tes_pkg::coord_t x0,
                                               input tes_pkg::coord_t y0,
                                               input tes_pkg::coord_t x1,
                                               input tes_pkg::coord_t y1);
    logic signed [CB:0] dx;
    logic [CB:0]        mag;
    logic [CB:0]        dy;
    tes_pkg::div_req_t  r;
    dx    = {x1[CB-1], x1} - {x0[CB-1], x0};
    mag   = dx[CB] ? (~dx + 1'b1) : dx;
    dy    = {y0[CB-1], y0} - {y1[CB-1], y1};
    r.num = {mag, {tes_pkg::FRAC_BITS{1'b0}}};
    r.den = DB'(dy) + DB'(1);
    r.neg = dx[CB];
    return r;
  endfunction

  // edge deltas
  always_comb begin
    req_nxt[0] = mk_req(tx_r, ty_r, bx_r, by_r);
    req_nxt[1] = mk_req(tx_r, ty_r, mx_r, my_r);
    req_nxt[2] = mk_req(mx_r, my_r, bx_r, by_r);
    side_nxt.top_x      = tx_r;
    side_nxt.top_y      = ty_r;
    side_nxt.rows_upper = RB'(ty_r - my_r);
    side_nxt.rows_total = RB'(ty_r - by_r);
  end

  assign req_vld = s2_vld_r;
  assign req     = req_r;
  assign side    = side_r;

endmodule

FILE: sv/tes_div.sv
// ----------------------------------------------------------------------------
// tes_div
// Pipelined restoring divider, one quotient bit per stage, sign applied last.
// ----------------------------------------------------------------------------
module tes_div (
  input  logic                                  clk,
  input  tes_pkg::div_req_t                     req,
  output logic signed [tes_pkg::SLOPE_BITS-1:0] quo
);

  localparam int NB = tes_pkg::NUM_BITS;
  localparam int DB = tes_pkg::DEN_BITS;

  // per-stage working state
  logic [NB-1:0] n_r   [NB+1];
  logic [NB-1:0] q_r   [NB+1];
  logic [DB:0]   rem_r [NB+1];
  logic [DB-1:0] d_r   [NB+1];
  logic          neg_r [NB+1];
  logic [NB-1:0] qf_r;

  always_comb begin
    n_r[0]   = req.num;
    q_r[0]   = '0;
    rem_r[0] = '0;
    d_r[0]   = req.den;
    neg_r[0] = req.neg;
  end

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [DB:0] sh;
    logic [DB:0] df;
    always_comb begin
      sh = {rem_r[i][DB-1:0], n_r[i][NB-1-i]};
      df = sh - {1'b0, d_r[i]};
    end
    always_ff @(posedge clk) begin
      n_r[i+1]   <= n_r[i];
      d_r[i+1]   <= d_r[i];
      neg_r[i+1] <= neg_r[i];
      q_r[i+1]   <= q_r[i] | (df[DB] ? '0 : (NB'(1) << (NB-1-i)));
      rem_r[i+1] <= df[DB] ? sh : df;
    end
  end

  // apply sign, sign-extend to slope width
  always_ff @(posedge clk) begin
    qf_r <= neg_r[NB] ? (~q_r[NB] + 1'b1) : q_r[NB];
  end

  assign quo = tes_pkg::SLOPE_BITS'(signed'(qf_r));

endmodule

FILE: sv/triangle_edge_setup_core.sv
// ----------------------------------------------------------------------------
// triangle_edge_setup_core
// Sorts three vertices by y and computes three 16.16 edge slopes.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  input   | in_ax..in_cy                   | start && !busy
//  result  | out_top_x..out_rows_total      | out_valid strobe, one cycle
//
//  pipeline: sort and delta registers, NUM_BITS divider stages, sign register
//  one request per cycle; three dividers of NUM_BITS radix-2 stages each
//  busy is always low; the receiver cannot stall
//  synchronous reset clears only the valid pipeline
module triangle_edge_setup_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [tes_pkg::COORD_BITS-1:0]  in_ax,
  input  logic signed [tes_pkg::COORD_BITS-1:0]  in_ay,
  input  logic signed [tes_pkg::COORD_BITS-1:0]  in_bx,
  input  logic signed [tes_pkg::COORD_BITS-1:0]  in_by,
  input  logic signed [tes_pkg::COORD_BITS-1:0]  in_cx,
  input  logic signed [tes_pkg::COORD_BITS-1:0]  in_cy,
  output logic                                   out_valid,
  output logic signed [tes_pkg::COORD_BITS-1:0]  out_top_x,
  output logic signed [tes_pkg::COORD_BITS-1:0]  out_top_y,
  output logic signed [tes_pkg::SLOPE_BITS-1:0]  out_slope_long,
  output logic signed [tes_pkg::SLOPE_BITS-1:0]  out_slope_upper,
  output logic signed [tes_pkg::SLOPE_BITS-1:0]  out_slope_lower,
  output logic        [tes_pkg::ROW_BITS-1:0]    out_rows_upper,
  output logic        [tes_pkg::ROW_BITS-1:0]    out_rows_total
);

  localparam int DLY = tes_pkg::NUM_BITS + 1;

  logic req_vld;
  tes_pkg::div_req_t [tes_pkg::N_EDGES-1:0] req;
  tes_pkg::side_t side;
  logic signed [tes_pkg::SLOPE_BITS-1:0] quo [tes_pkg::N_EDGES];
  logic           vld_r  [DLY];
  tes_pkg::side_t side_r [DLY];

  assign busy = 1'b0;

  // sort and delta stages
  tes_sort u_sort (
    .clk(clk), .rst_n(rst_n), .in_vld(start),
    .ax(in_ax), .ay(in_ay), .bx(in_bx), .by(in_by), .cx(in_cx), .cy(in_cy),
    .req_vld(req_vld), .req(req), .side(side)
  );

  // one divider per edge
  for (genvar e = 0; e < tes_pkg::N_EDGES; e++) begin : g_div
    tes_div u_div (.clk(clk), .req(req[e]), .quo(quo[e]));
  end

  // valid and sideband delay matching the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= req_vld;
      for (int i = 1; i < DLY; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side;
    for (int i = 1; i < DLY; i++) side_r[i] <= side_r[i-1];
  end

  assign out_valid       = vld_r[DLY-1];
  assign out_top_x       = side_r[DLY-1].top_x;
  assign out_top_y       = side_r[DLY-1].top_y;
  assign out_rows_upper  = side_r[DLY-1].rows_upper;
  assign out_rows_total  = side_r[DLY-1].rows_total;
  assign out_slope_long  = quo[0];
  assign out_slope_upper = quo[1];
  assign out_slope_lower = quo[2];

endmodule

FILE: tb/sv/tb_triangle_edge_setup_core.sv
// ----------------------------------------------------------------------------
// tb_triangle_edge_setup_core
// Drives random and corner-case triangles into the edge setup core, predicts
// the sorted top vertex, slopes and row counts, and checks every strobe.
// ----------------------------------------------------------------------------
module tb_triangle_edge_setup_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [tes_pkg::COORD_BITS-1:0] top_x, top_y;
    logic signed [tes_pkg::SLOPE_BITS-1:0] slope_long, slope_upper, slope_lower;
    logic [tes_pkg::ROW_BITS-1:0]          rows_upper, rows_total;
  } edge_setup_t;

  // scoreboard of pending edge setups
  class setup_board;
    edge_setup_t pending[$];
    int          fails;
    int          seen;

    function automatic logic signed [tes_pkg::SLOPE_BITS-1:0] slope(
      longint xa, longint ya, longint xb, longint yb);
      longint num, den;
      num = (xb - xa) * 65536;
      den = ya - yb + 1;
      if (den < 1) den = 1;
      return tes_pkg::SLOPE_BITS'(num / den);
    endfunction

    function void note(tes_pkg::coord_t ax, tes_pkg::coord_t ay,
                       tes_pkg::coord_t bx, tes_pkg::coord_t by,
                       tes_pkg::coord_t cx, tes_pkg::coord_t cy);
      longint      vx[3], vy[3];
      int          t, m, b;
      logic [2:0]  code;
      edge_setup_t e;
      vx[0] = ax; vy[0] = ay; vx[1] = bx; vy[1] = by; vx[2] = cx; vy[2] = cy;
      code = ((vy[0] >= vy[1]) ? tes_pkg::FLAG_AB : 3'b0)
           | ((vy[1] >= vy[2]) ? tes_pkg::FLAG_BC : 3'b0)
           | ((vy[0] >= vy[2]) ? tes_pkg::FLAG_AC : 3'b0);
      case (code)
        tes_pkg::CODE_CBA: begin t = 2; m = 1; b = 0; end
        tes_pkg::CODE_BCA: begin t = 1; m = 2; b = 0; end
        tes_pkg::CODE_BAC: begin t = 1; m = 0; b = 2; end
        tes_pkg::CODE_CAB: begin t = 2; m = 0; b = 1; end
        tes_pkg::CODE_ACB: begin t = 0; m = 2; b = 1; end
        default:           begin t = 0; m = 1; b = 2; end
      endcase
      e.top_x = tes_pkg::COORD_BITS'(vx[t]);
      e.top_y = tes_pkg::COORD_BITS'(vy[t]);
      e.slope_long  = slope(vx[t], vy[t], vx[b], vy[b]);
      e.slope_upper = slope(vx[t], vy[t], vx[m], vy[m]);
      e.slope_lower = slope(vx[m], vy[m], vx[b], vy[b]);
      e.rows_upper = tes_pkg::ROW_BITS'(vy[t] - vy[m]);
      e.rows_total = tes_pkg::ROW_BITS'(vy[t] - vy[b]);
      pending.push_back(e);
    endfunction

    function void check(edge_setup_t got);
      edge_setup_t e;
      seen++;
      if (pending.size() == 0) begin
        $error("result strobe with no request pending");
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.top_x !== e.top_x) begin
        $error("top_x exp %0d got %0d", e.top_x, got.top_x); fails++; end
      if (got.top_y !== e.top_y) begin
        $error("top_y exp %0d got %0d", e.top_y, got.top_y); fails++; end
      if (got.slope_long !== e.slope_long) begin
        $error("slope_long exp %0d got %0d", e.slope_long, got.slope_long); fails++; end
      if (got.slope_upper !== e.slope_upper) begin
        $error("slope_upper exp %0d got %0d", e.slope_upper, got.slope_upper); fails++; end
      if (got.slope_lower !== e.slope_lower) begin
        $error("slope_lower exp %0d got %0d", e.slope_lower, got.slope_lower); fails++; end
      if (got.rows_upper !== e.rows_upper) begin
        $error("rows_upper exp %0d got %0d", e.rows_upper, got.rows_upper); fails++; end
      if (got.rows_total !== e.rows_total) begin
        $error("rows_total exp %0d got %0d", e.rows_total, got.rows_total); fails++; end
    endfunction
  endclass

  logic clk = 1'b0, rst_n = 1'b0, start = 1'b0;
  logic busy, out_valid;
  tes_pkg::coord_t in_ax = '0, in_ay = '0, in_bx = '0, in_by = '0, in_cx = '0, in_cy = '0;
  logic signed [tes_pkg::COORD_BITS-1:0] out_top_x, out_top_y;
  logic signed [tes_pkg::SLOPE_BITS-1:0] out_slope_long, out_slope_upper, out_slope_lower;
  logic [tes_pkg::ROW_BITS-1:0]          out_rows_upper, out_rows_total;

  setup_board board = new();
  int         sent;

  triangle_edge_setup_core dut (.*);

  initial forever #5 clk = ~clk;

  // generous watchdog
  initial begin
    #2ms;
    $display("tb_triangle_edge_setup_core failed");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    edge_setup_t r;
    if (rst_n && out_valid === 1'b1) begin
      r.top_x = out_top_x; r.top_y = out_top_y;
      r.slope_long = out_slope_long; r.slope_upper = out_slope_upper;
      r.slope_lower = out_slope_lower;
      r.rows_upper = out_rows_upper; r.rows_total = out_rows_total;
      board.check(r);
    end
  end

  // present one request and hold it until accepted
  task automatic send_tri(tes_pkg::coord_t ax, tes_pkg::coord_t ay,
                          tes_pkg::coord_t bx, tes_pkg::coord_t by,
                          tes_pkg::coord_t cx, tes_pkg::coord_t cy);
    start <= 1'b1;
    in_ax <= ax; in_ay <= ay; in_bx <= bx; in_by <= by; in_cx <= cx; in_cy <= cy;
    do @(posedge clk); while (busy !== 1'b0);
    board.note(ax, ay, bx, by, cx, cy);
    sent++;
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic tes_pkg::coord_t rnd_coord(bit narrow);
    case ($urandom_range(0, 5))
      0: return tes_pkg::coord_t'(-2048);
      1: return tes_pkg::coord_t'(2047);
      default: return narrow ? tes_pkg::coord_t'($urandom_range(0, 40) - 20)
                             : tes_pkg::coord_t'($urandom());
    endcase
  endfunction

  initial begin
    tes_pkg::coord_t mn, mx, v[6];
    mn = tes_pkg::coord_t'(-2048);
    mx = tes_pkg::coord_t'(2047);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: every sort order, ties, degenerate and extreme edges
    send_tri(0, 0, 0, 0, 0, 0);
    send_tri(mn, mn, mx, mx, mn, mx);
    send_tri(mx, mn, mn, mx, mx, mx);
    send_tri(mn, mx, mx, mn, 0, 0);
    send_tri(mx, mx, mn, mn, mx, mn);
    send_tri(1, 1, 2, 2, 3, 3);
    send_tri(1, 3, 2, 2, 3, 1);
    send_tri(1, 1, 2, 3, 3, 2);
    send_tri(1, 2, 2, 3, 3, 1);
    send_tri(1, 2, 2, 1, 3, 3);
    send_tri(1, 3, 2, 1, 3, 2);
    send_tri(5, 7, -5, 7, 0, 7);
    send_tri(5, 7, -5, 7, 0, -7);
    send_tri(5, -7, -5, 7, 0, 7);
    send_tri(mx, 0, mn, 0, mx, 0);
    send_tri(-1, -1, -1, -1, -1, -1);
    send_tri(mn, mx, mx, mx, mn, mn);

    // wait for the pipeline to drain completely once
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    // random part: bursts of idle, last part back-to-back
    for (int i = 0; i < 1350; i++) begin
      bit narrow;
      narrow = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 6; k++) v[k] = rnd_coord(narrow);
      if ($urandom_range(0, 7) == 0) v[3] = v[1];
      if ($urandom_range(0, 7) == 0) v[5] = v[$urandom_range(0, 1) ? 1 : 3];
      send_tri(v[0], v[1], v[2], v[3], v[4], v[5]);
      if (i < 1100 && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 6));
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d triangles, checked %0d results across all sort orders and ties",
             sent, board.seen);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("tb_triangle_edge_setup_core passed");
    else
      $display("tb_triangle_edge_setup_core failed");
    $finish;
  end
endmodule
